// ===== rtl/core/seg7_decimal_entry_scanner_top_macros.svh =====
// Assertion macros for the seven-segment entry scanner; expect clk_i and rst_ni in scope.
`ifndef SEG7_DECIMAL_ENTRY_SCANNER_TOP_MACROS_SVH
`define SEG7_DECIMAL_ENTRY_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define S7DE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define S7DE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/s7de_pkg.sv =====
// Shared types, widths and codes for the seven-segment entry scanner.
`default_nettype none

package s7de_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned SHOWN_W    = 14;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned DIGITS_DEF = 4;

  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;
  localparam logic [CODE_W-1:0] CODE_MAX   = 4'd9;
  localparam logic [SEG_W-1:0]  SEG_OFF    = 8'hff;
  localparam logic [SEL_W-1:0]  SEL_NONE   = 4'hf;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_APPEND = 2'd2
  } op_e;

  typedef struct packed {
    logic               start;
    logic               append;
    logic [VALUE_W-1:0] value;
  } conv_req_t;

  // Active-low common-anode pattern, bit0 is segment a.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    unique case (code)
      4'd0:    pat = 8'hc0;
      4'd1:    pat = 8'hf9;
      4'd2:    pat = 8'ha4;
      4'd3:    pat = 8'hb0;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h92;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'hf8;
      4'd8:    pat = 8'h80;
      4'd9:    pat = 8'h90;
      default: pat = SEG_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/seg7_decimal_entry_scanner_top.sv =====
// Top level of the multiplexed seven-segment display driver with decimal entry.
//
//  Channel  Dir  Signals                         Payload (low bit first)
//  s_axis   in   s_axis_tvalid/tready/tdata[23]  op[1:0], value[17:2]
//  m_axis   out  m_axis_tvalid/tready/tdata[31]  segments[7:0], digit_select[11:8],
//                                                shown_value[25:12], blank[26]
//
// One request at a time. A scan tick or an ignored request passes the state register
// to the result register; an append first passes through the digit-serial pack, a set
// through the bit-serial BCD conversion and then the pack, both in s7de_conv.
// Reset leaves the display blank with all segments and selects off.
// A stalled result waits in the output register while the next request is taken;
// that request then holds in its last cycle until the register frees.
`default_nettype none

module seg7_decimal_entry_scanner_top #(
  parameter int unsigned DIGITS = s7de_pkg::DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // op[1:0], value[17:2], zero[23:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // segments, digit_select, shown_value, blank, zero
);
  import s7de_pkg::*;

  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [DIGITS-1:0][CODE_W-1:0]  codes_q, conv_codes;
  logic                           blank_q;
  logic [SHOWN_W-1:0]             value_q, conv_value;
  logic [IDX_W-1:0]               scan_q;
  logic [SEG_W-1:0]               seg_q;
  logic [SEL_W-1:0]               sel_q;
  logic                           m_valid_q;
  logic [31:0]                    m_data_q;
  logic                           conv_done;
  conv_req_t                      conv_req;
  logic                           in_fire, slot_free;
  logic [1:0]                     in_op;
  logic [VALUE_W-1:0]             in_value;
  logic                           do_tick;

  assign in_op     = s_axis_tdata[1:0];
  assign in_value  = s_axis_tdata[17:2];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d        = state_q;
    conv_req.start  = 1'b0;
    conv_req.append = 1'b0;
    conv_req.value  = in_value;
    do_tick         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_OUT;
          unique case (in_op)
            OP_TICK: do_tick = 1'b1;
            OP_SET: begin
              conv_req.start = 1'b1;
              state_d        = ST_BUSY;
            end
            OP_APPEND: begin
              // Drop keys above nine.
              if (in_value <= VALUE_W'(CODE_MAX)) begin
                conv_req.start  = 1'b1;
                conv_req.append = 1'b1;
                state_d         = ST_BUSY;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_BUSY: begin
        if (conv_done) begin
          state_d = ST_OUT;
        end
      end
      default: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  s7de_conv #(
    .DIGITS (DIGITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (conv_req),
    .codes_i (codes_q),
    .done_o  (conv_done),
    .codes_o (conv_codes),
    .value_o (conv_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      blank_q   <= 1'b1;
      value_q   <= '0;
      scan_q    <= '0;
      seg_q     <= SEG_OFF;
      sel_q     <= SEL_NONE;
      for (int i = 0; i < DIGITS; i++) begin
        codes_q[i] <= CODE_BLANK;
      end
    end else begin
      state_q <= state_d;
      if (do_tick) begin
        seg_q  <= seg_pattern(codes_q[scan_q]);
        sel_q  <= ~(SEL_W'(1) << scan_q);
        scan_q <= (scan_q == IDX_W'(DIGITS - 1)) ? '0 : scan_q + 1'b1;
      end
      if (state_q == ST_BUSY && conv_done) begin
        codes_q <= conv_codes;
        value_q <= conv_value;
        blank_q <= 1'b0;
      end
      if (state_q == ST_OUT && slot_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && slot_free) begin
      m_data_q <= {5'b0, blank_q, value_q, sel_q, seg_q};
    end
  end

`include "seg7_decimal_entry_scanner_top_macros.svh"

  `S7DE_ASSERT_IMP(a_blank_zero, blank_q, value_q == '0, "blank display holds a nonzero value")
  `S7DE_ASSERT_IMP(a_sel_cold, 1'b1, sel_q == SEL_NONE || $countones(sel_q) == SEL_W - 1,
                   "digit select is not one-cold")
  `S7DE_ASSERT_IMP(a_done_busy, conv_done, state_q == ST_BUSY, "conversion ended outside busy")
  `S7DE_ASSERT_NXT(a_one_at_time, in_fire, !s_axis_tready, "request taken while one in work")

endmodule

`default_nettype wire

// ===== rtl/core/s7de_conv.sv =====
// Iterative binary-to-BCD converter and digit packer with leading-zero blanking.
`default_nettype none

module s7de_conv #(
  parameter int unsigned DIGITS = s7de_pkg::DIGITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  s7de_pkg::conv_req_t                      req_i,
  input  logic [DIGITS-1:0][s7de_pkg::CODE_W-1:0]  codes_i,
  output logic                                     done_o,
  output logic [DIGITS-1:0][s7de_pkg::CODE_W-1:0]  codes_o,
  output logic [s7de_pkg::SHOWN_W-1:0]             value_o
);
  import s7de_pkg::*;

  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(VALUE_W);

  localparam logic [1:0] CV_IDLE   = 2'd0;
  localparam logic [1:0] CV_DABBLE = 2'd1;
  localparam logic [1:0] CV_PACK   = 2'd2;
  localparam logic [1:0] CV_FINISH = 2'd3;

  logic [1:0]                           state_q, state_d;
  logic [VALUE_W-1:0]                   bin_q, bin_d;
  logic [BCD_DIGITS-1:0][CODE_W-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [BCD_DIGITS*CODE_W-1:0]         bcd_flat;
  logic [DIGITS-1:0][CODE_W-1:0]        win_q, win_d, win_rot, win_load;
  logic [CNT_W-1:0]                     cnt_q, cnt_d;
  logic [IDX_W-1:0]                     pos_q, pos_d, top_q, top_d;
  logic [SHOWN_W-1:0]                   acc_q, acc_d, acc_next;
  logic                                 found_q, found_d;
  logic [CODE_W-1:0]                    head;

  // Shift-and-add-3 step shared by every bit of the set value.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign bcd_flat = bcd_adj;
  assign bcd_d    = {bcd_flat[BCD_DIGITS*CODE_W-2:0], bin_q[VALUE_W-1]};

  // Horner step: acc * 10 + digit, fed from the top of the rotating window.
  assign head     = win_q[DIGITS-1];
  assign acc_next = SHOWN_W'({acc_q, 3'b000}) + SHOWN_W'({acc_q, 1'b0}) + SHOWN_W'(head);

  always_comb begin
    win_rot[0] = win_q[DIGITS-1];
    for (int i = 1; i < DIGITS; i++) begin
      win_rot[i] = win_q[i-1];
    end
  end

  // Append: shift held digits up one place, blanks count as zero.
  always_comb begin
    win_load[0] = req_i.value[CODE_W-1:0];
    for (int i = 1; i < DIGITS; i++) begin
      win_load[i] = (codes_i[i-1] > CODE_MAX) ? '0 : codes_i[i-1];
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    top_d   = top_q;
    found_d = found_q;
    done_o  = 1'b0;
    unique case (state_q)
      CV_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          top_d   = '0;
          found_d = 1'b0;
          pos_d   = IDX_W'(DIGITS - 1);
          cnt_d   = CNT_W'(VALUE_W - 1);
          bin_d   = req_i.value;
          if (req_i.append) begin
            win_d   = win_load;
            state_d = CV_PACK;
          end else begin
            state_d = CV_DABBLE;
          end
        end
      end
      CV_DABBLE: begin
        bin_d = {bin_q[VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // Keep only the low digits: this is the modulo of the set value.
          for (int i = 0; i < DIGITS; i++) begin
            win_d[i] = bcd_d[i];
          end
          state_d = CV_PACK;
        end
      end
      CV_PACK: begin
        acc_d = acc_next;
        win_d = win_rot;
        pos_d = pos_q - 1'b1;
        if (!found_q && head != '0) begin
          top_d   = pos_q;
          found_d = 1'b1;
        end
        if (pos_q == '0) begin
          state_d = CV_FINISH;
        end
      end
      default: begin
        done_o  = 1'b1;
        state_d = CV_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      codes_o[i] = (IDX_W'(i) <= top_q) ? win_q[i] : CODE_BLANK;
    end
  end

  assign value_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    win_q <= win_d;
    acc_q <= acc_d;
    top_q <= top_d;
    if (state_q == CV_IDLE) begin
      bcd_q <= '0;
    end else begin
      bcd_q <= bcd_d;
    end
  end

endmodule

`default_nettype wire
